/* design/bmg_pkg.sv */
// Shared constants and types for the Box-Muller Gaussian sample unit.
package bmg_pkg;

  localparam int FRAC_BITS    = 28;
  localparam int HORNER_STEPS = 6;
  localparam int RECIP_SHIFT  = 38;

  // Register stages per unit, input to output.
  localparam int LOG_LAT   = 31;
  localparam int SQRT_LAT  = 31;
  localparam int COS_LAT   = 15;
  localparam int ANGLE_DLY = LOG_LAT + SQRT_LAT - COS_LAT;
  localparam int SCALE_DLY = LOG_LAT + SQRT_LAT + 2;

  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  typedef logic [7:0] div_t;

  localparam div_t COS_DIV [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam div_t SIN_DIV [HORNER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  typedef struct packed {
    logic signed [31:0] mean;
    logic [30:0]        sigma;
  } scale_t;

endpackage

/* design/box_muller_gaussian_sample_unit.sv */
// Top level of the Box-Muller Gaussian sample unit.
//
// Usage: the input channel (in_valid/in_ready) takes one beat of two uniform
// fractions u_radius and u_angle (unsigned, over 2^32), a mean (signed Q16.16)
// and a sigma (unsigned Q15.16). The output channel (out_valid/out_ready)
// returns one beat per input: sample = r*cos(a)*sigma + mean in Q16.16, with
// saturated set when the sum was clipped to the 32-bit range.
// Throughput: one beat per cycle, sustained, while out_ready is high.
// Path from input beat to output valid: input register, 31 log stages, 31
// square-root stages, two scaling multiplies, output register; the log and
// square-root chains set most of that depth, with one root bit per sqrt stage.
// The cosine path runs in parallel on a delayed angle.
// Stall: when out_ready is low the output register holds, one more beat lands
// in a skid register, and then in_ready drops and the whole pipeline freezes
// without losing or repeating beats. in_ready depends on registers only.
// Reset: rst (synchronous, active high) clears all valid bits, the skid's
// valid bit included; in-flight beats are dropped.
module box_muller_gaussian_sample_unit #(
  parameter int UNIFORM_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        u_radius,
  input  logic [31:0]        u_angle,
  input  logic signed [31:0] mean,
  input  logic [30:0]        sigma,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sample,
  output logic               saturated
);
  import bmg_pkg::*;

  localparam int KEEP = (UNIFORM_BITS >= 32) ? 32 : UNIFORM_BITS;
  localparam logic [31:0] U_MASK = ~((32'd1 << (32 - KEEP)) - 32'd1);

  logic        en;

  logic        s0_valid;
  logic [31:0] s0_ur;
  logic [31:0] s0_ua;
  scale_t      s0_scale;

  logic        log_valid;
  logic [33:0] two_ln;
  logic        rad_valid;
  logic [30:0] radius;

  logic [31:0] ad [ANGLE_DLY];
  scale_t      sd [SCALE_DLY];

  logic [30:0] cmag;
  logic        cneg;

  logic [61:0] prod1;
  logic        f1_valid;
  logic [30:0] f1_mag;
  logic        f1_neg;

  logic [61:0] prod2;
  logic        f2_valid;
  logic [33:0] f2_mag;
  logic        f2_neg;

  logic signed [35:0] magv;
  logic signed [35:0] val;
  logic               sat_hi;
  logic               sat_lo;
  logic signed [31:0] sample_next;
  logic               sat_next;

  logic               skid_valid;
  logic signed [31:0] skid_sample;
  logic               skid_sat;

  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ur          <= u_radius & U_MASK;
      s0_ua          <= u_angle & U_MASK;
      s0_scale.mean  <= mean;
      s0_scale.sigma <= sigma;
    end
  end

  bmg_log2 u_log (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .u         (s0_ur),
    .out_valid (log_valid),
    .two_ln    (two_ln)
  );

  bmg_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (log_valid),
    .two_ln    (two_ln),
    .out_valid (rad_valid),
    .radius    (radius)
  );

  // side delay lines keep angle and scale aligned with the radius
  always_ff @(posedge clk) begin
    if (en) begin
      ad[0] <= s0_ua;
      sd[0] <= s0_scale;
      for (int i = 1; i < ANGLE_DLY; i++) begin
        ad[i] <= ad[i-1];
      end
      for (int i = 1; i < SCALE_DLY; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  bmg_cos u_cos (
    .clk   (clk),
    .en    (en),
    .phase (ad[ANGLE_DLY-1]),
    .cmag  (cmag),
    .neg   (cneg)
  );

  assign prod1 = radius * cmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= rad_valid;
      f2_valid <= f1_valid;
    end
  end

  assign prod2 = f1_mag * sd[SCALE_DLY-2].sigma;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_mag <= prod1[60:30];
      f1_neg <= cneg;
      f2_mag <= prod2[61:28];
      f2_neg <= f1_neg;
    end
  end

  assign magv        = signed'({2'b00, f2_mag});
  assign val         = (f2_neg ? -magv : magv) + 36'(sd[SCALE_DLY-1].mean);
  assign sat_hi      = (val > 36'sd2147483647);
  assign sat_lo      = (val < -36'sd2147483648);
  assign sample_next = sat_hi ? 32'sh7FFF_FFFF : (sat_lo ? 32'sh8000_0000 : val[31:0]);
  assign sat_next    = sat_hi || sat_lo;

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_ready) begin
      out_valid <= f2_valid;
    end else if (f2_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        sample    <= skid_sample;
        saturated <= skid_sat;
      end
    end else if (!out_valid || out_ready) begin
      sample    <= sample_next;
      saturated <= sat_next;
    end else begin
      skid_sample <= sample_next;
      skid_sat    <= sat_next;
    end
  end

  `ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready && f2_valid))
    else $error("skid filled without a stalled output");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (sample == 32'sh7FFF_FFFF || sample == 32'sh8000_0000))
    else $error("saturated flag without a clipped sample");
  `endif

endmodule

/* design/bmg_log2.sv */
// Pipelined 2*ln(1/(1-u)) in Q.28: normalize, 28 squaring stages, scale by ln2.
module bmg_log2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] u,
  output logic        out_valid,
  output logic [33:0] two_ln
);
  import bmg_pkg::*;

  logic [32:0] d;
  logic [32:0] xa;
  logic [5:0]  ca;
  logic [32:0] xb;
  logic [5:0]  cb;

  logic        na_valid;
  logic [32:0] na_x;
  logic [5:0]  na_cnt;

  logic        sq_valid [FRAC_BITS+1];
  logic [31:0] sq_m     [FRAC_BITS+1];
  logic [27:0] sq_frac  [FRAC_BITS+1];
  logic [5:0]  sq_lz    [FRAC_BITS+1];

  logic [33:0] nl2;
  logic [63:0] ln_prod;

  // leading-zero normalize, coarse part
  always_comb begin
    d  = 33'h1_0000_0000 - {1'b0, u};
    xa = d;
    ca = '0;
    if (xa[32:1] == '0) begin
      xa = xa << 32;
      ca = ca + 6'd32;
    end
    if (xa[32:17] == '0) begin
      xa = xa << 16;
      ca = ca + 6'd16;
    end
    if (xa[32:25] == '0) begin
      xa = xa << 8;
      ca = ca + 6'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      na_valid <= 1'b0;
    end else if (en) begin
      na_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_x   <= xa;
      na_cnt <= ca;
    end
  end

  // fine part
  always_comb begin
    xb = na_x;
    cb = na_cnt;
    if (xb[32:29] == '0) begin
      xb = xb << 4;
      cb = cb + 6'd4;
    end
    if (xb[32:31] == '0) begin
      xb = xb << 2;
      cb = cb + 6'd2;
    end
    if (!xb[32]) begin
      xb = xb << 1;
      cb = cb + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= na_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_m[0]    <= xb[32:1];
      sq_frac[0] <= '0;
      sq_lz[0]   <= cb;
    end
  end

  // one fraction bit of log2 per stage
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_sq
    logic [63:0] prod;
    logic        hi;

    assign prod = sq_m[i] * sq_m[i];
    assign hi   = prod[63];

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[i+1] <= 1'b0;
      end else if (en) begin
        sq_valid[i+1] <= sq_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_m[i+1]    <= hi ? prod[63:32] : prod[62:31];
        sq_frac[i+1] <= {sq_frac[i][26:0], hi};
        sq_lz[i+1]   <= sq_lz[i];
      end
    end
  end

  assign nl2     = {sq_lz[FRAC_BITS], 28'd0} - {6'd0, sq_frac[FRAC_BITS]};
  assign ln_prod = nl2 * LN2_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_valid[FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      two_ln <= ln_prod[62:29];
    end
  end

endmodule

/* design/bmg_sqrt.sv */
// Pipelined restoring square root of two_ln in Q.28, one root bit per stage.
module bmg_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [33:0] two_ln,
  output logic        out_valid,
  output logic [30:0] radius
);
  import bmg_pkg::*;

  logic        sv   [SQRT_LAT];
  logic [32:0] sr   [SQRT_LAT];
  logic [30:0] sq   [SQRT_LAT];
  logic [61:0] srad [SQRT_LAT];

  for (genvar j = 0; j < SQRT_LAT; j++) begin : g_stage
    logic        vi;
    logic [32:0] ri;
    logic [30:0] qi;
    logic [61:0] radi;
    logic [34:0] rr;
    logic [34:0] trial;
    logic        take;

    if (j == 0) begin : g_first
      assign vi   = in_valid;
      assign ri   = '0;
      assign qi   = '0;
      assign radi = {two_ln, 28'd0};
    end else begin : g_next
      assign vi   = sv[j-1];
      assign ri   = sr[j-1];
      assign qi   = sq[j-1];
      assign radi = srad[j-1];
    end

    assign rr    = {ri, radi[61:60]};
    assign trial = {2'b00, qi, 2'b01};
    assign take  = (rr >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[j] <= 1'b0;
      end else if (en) begin
        sv[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr[j]   <= take ? 33'(rr - trial) : rr[32:0];
        sq[j]   <= {qi[29:0], take};
        srad[j] <= radi << 2;
      end
    end
  end

  assign out_valid = sv[SQRT_LAT-1];
  assign radius    = sq[SQRT_LAT-1];

  `ifndef SYNTHESIS
  // remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    sv[SQRT_LAT-1] |-> ({1'b0, sr[SQRT_LAT-1]} <= {1'b0, sq[SQRT_LAT-1], 1'b0}))
    else $error("sqrt remainder out of range");
  `endif

endmodule

/* design/bmg_cos.sv */
// Pipelined |cos(2*pi*phase)| in Q.30 with sign, Horner polynomials per octant.
module bmg_cos (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] phase,
  output logic [30:0] cmag,
  output logic        neg
);
  import bmg_pkg::*;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } ang_t;

  logic [29:0] r30;
  logic        sw;
  logic [29:0] a;
  logic [60:0] prod_x;

  logic [29:0] s1_x;
  logic [1:0]  s1_quad;
  logic        s1_swap;

  logic [59:0] prod_x2;
  ang_t        a2;

  ang_t        ana [HORNER_STEPS];
  ang_t        anb [HORNER_STEPS];
  logic [29:0] pc  [HORNER_STEPS];
  logic [29:0] ps  [HORNER_STEPS];
  logic [30:0] tcb [HORNER_STEPS];
  logic [30:0] tsb [HORNER_STEPS];

  ang_t        af;
  logic [60:0] prod_s;
  logic [30:0] s_val;
  logic [30:0] c_val;
  logic [30:0] cphi;
  logic [30:0] sphi;

  // fold to the first octant of the quadrant
  assign r30    = phase[29:0];
  assign sw     = r30[29];
  assign a      = sw ? 30'(31'h4000_0000 - {1'b0, r30}) : r30;
  assign prod_x = a * HALF_PI_Q30;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x    <= prod_x[59:30];
      s1_quad <= phase[31:30];
      s1_swap <= sw;
    end
  end

  assign prod_x2 = s1_x * s1_x;

  always_ff @(posedge clk) begin
    if (en) begin
      a2.x    <= s1_x;
      a2.x2   <= prod_x2[59:30];
      a2.quad <= s1_quad;
      a2.swap <= s1_swap;
    end
  end

  // each step: multiply by x2, divide by a constant via reciprocal, subtract from one
  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    localparam logic [37:0] RC = 38'(((64'd1 << RECIP_SHIFT) + 64'(COS_DIV[k]) - 64'd1)
                                     / 64'(COS_DIV[k]));
    localparam logic [37:0] RS = 38'(((64'd1 << RECIP_SHIFT) + 64'(SIN_DIV[k]) - 64'd1)
                                     / 64'(SIN_DIV[k]));
    ang_t        ang_in;
    logic [30:0] tc_in;
    logic [30:0] ts_in;
    logic [60:0] mc;
    logic [60:0] ms;
    logic [67:0] qc;
    logic [67:0] qs;

    if (k == 0) begin : g_first
      assign ang_in = a2;
      assign tc_in  = ONE_Q30;
      assign ts_in  = ONE_Q30;
    end else begin : g_next
      assign ang_in = anb[k-1];
      assign tc_in  = tcb[k-1];
      assign ts_in  = tsb[k-1];
    end

    assign mc = ang_in.x2 * tc_in;
    assign ms = ang_in.x2 * ts_in;

    always_ff @(posedge clk) begin
      if (en) begin
        ana[k] <= ang_in;
        pc[k]  <= mc[59:30];
        ps[k]  <= ms[59:30];
      end
    end

    assign qc = pc[k] * RC;
    assign qs = ps[k] * RS;

    always_ff @(posedge clk) begin
      if (en) begin
        anb[k] <= ana[k];
        tcb[k] <= ONE_Q30 - {1'b0, qc[67:38]};
        tsb[k] <= ONE_Q30 - {1'b0, qs[67:38]};
      end
    end
  end

  assign af     = anb[HORNER_STEPS-1];
  assign c_val  = tcb[HORNER_STEPS-1];
  assign prod_s = af.x * tsb[HORNER_STEPS-1];
  assign s_val  = {1'b0, prod_s[59:30]};
  assign cphi   = af.swap ? s_val : c_val;
  assign sphi   = af.swap ? c_val : s_val;

  always_ff @(posedge clk) begin
    if (en) begin
      cmag <= (af.quad == 2'd0 || af.quad == 2'd2) ? cphi : sphi;
      neg  <= (af.quad == 2'd1 || af.quad == 2'd2);
    end
  end

endmodule
